[design/tcphp_pkg.sv]
// ----------------------------------------------------------------------------
// tcphp_pkg
// Shared types and constants for the TCP header parse and check block.
// ----------------------------------------------------------------------------
package tcphp_pkg;

  localparam int unsigned HeaderBytes = 20;
  localparam int unsigned PosW        = 5;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueueAw     = $clog2(QueueDepth);

  localparam logic [PosW-1:0] PosLast = PosW'(HeaderBytes - 1);
  localparam logic [PosW-1:0] PosDone = PosW'(HeaderBytes);

  localparam logic [7:0] OffsetMask   = 8'hF0;
  localparam logic [7:0] ReservedMask = 8'h0F;

  localparam logic [2:0] VerdictAllow    = 3'd0;
  localparam logic [2:0] VerdictSrcZero  = 3'd1;
  localparam logic [2:0] VerdictDstZero  = 3'd2;
  localparam logic [2:0] VerdictReserved = 3'd3;
  localparam logic [2:0] VerdictFlagNull = 3'd4;

  // one classified header byte, as queued between front and back
  typedef struct packed {
    logic [7:0]      data;
    logic            start;
    logic            live;   // byte falls inside a header window
    logic [PosW-1:0] pos;    // header byte index when live
  } entry_t;

endpackage

[design/tcphp_front.sv]
// ----------------------------------------------------------------------------
// tcphp_front
// Tags each accepted byte with its header byte index since the last start.
// ----------------------------------------------------------------------------
module tcphp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       data_byte,
  input  logic             start_of_header,
  output tcphp_pkg::entry_t entry
);
  import tcphp_pkg::*;

  // saturates at PosDone: no byte beyond the window is live
  logic [PosW-1:0] byte_count;
  logic [PosW-1:0] byte_count_next;

  always_comb begin
    entry.data  = data_byte;
    entry.start = start_of_header;
    entry.live  = start_of_header || (byte_count != PosDone);
    entry.pos   = start_of_header ? '0 : byte_count;
    if (start_of_header) begin
      byte_count_next = PosW'(1);
    end else if (byte_count != PosDone) begin
      byte_count_next = byte_count + PosW'(1);
    end else begin
      byte_count_next = byte_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= PosDone;
    end else if (take) begin
      byte_count <= byte_count_next;
    end
  end

endmodule

[design/tcphp_queue.sv]
// ----------------------------------------------------------------------------
// tcphp_queue
// Small FIFO between the classifying front and the parsing back.
// ----------------------------------------------------------------------------
module tcphp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tcphp_pkg::entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output tcphp_pkg::entry_t head_entry
);
  import tcphp_pkg::*;

  entry_t             slots [QueueDepth];
  logic [QueueAw-1:0] wr_ptr;
  logic [QueueAw-1:0] rd_ptr;
  logic [QueueAw:0]   fill;

  assign full       = (fill == (QueueAw+1)'(QueueDepth));
  assign head_valid = (fill != '0);
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QueueAw'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QueueAw'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + (QueueAw+1)'(1);
        2'b01:   fill <= fill - (QueueAw+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

[design/tcphp_back.sv]
// ----------------------------------------------------------------------------
// tcphp_back
// Captures header fields, runs the sanity checks, holds the result register.
// ----------------------------------------------------------------------------
module tcphp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  tcphp_pkg::entry_t head_entry,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        verdict,
  output logic [15:0]       source_port,
  output logic [15:0]       destination_port,
  output logic [31:0]       sequence_number,
  output logic [31:0]       acknowledgment_number,
  output logic [3:0]        header_words,
  output logic [7:0]        flag_bits,
  output logic [15:0]       window_size,
  output logic [15:0]       header_checksum,
  output logic [15:0]       urgent_pointer
);
  import tcphp_pkg::*;

  logic        parse_active;
  logic [31:0] port_pair;
  logic [31:0] seq_value;
  logic [31:0] ack_value;
  logic [11:0] offset_and_flags;
  logic [47:0] tail_fields;

  logic        parse_active_next;
  logic [31:0] port_pair_next;
  logic [31:0] seq_value_next;
  logic [31:0] ack_value_next;
  logic [11:0] offset_and_flags_next;
  logic [47:0] tail_fields_next;
  logic        done;
  logic [2:0]  code;
  logic        working;
  logic [7:0]  b;
  logic [PosW-1:0] pos;

  assign pop = head_valid && (!out_valid || !out_stall);
  assign b   = head_entry.data;
  assign pos = head_entry.pos;

  always_comb begin
    // start clears every captured field
    if (head_entry.start) begin
      port_pair_next        = '0;
      seq_value_next        = '0;
      ack_value_next        = '0;
      offset_and_flags_next = '0;
      tail_fields_next      = '0;
      parse_active_next     = 1'b1;
    end else begin
      port_pair_next        = port_pair;
      seq_value_next        = seq_value;
      ack_value_next        = ack_value;
      offset_and_flags_next = offset_and_flags;
      tail_fields_next      = tail_fields;
      parse_active_next     = parse_active;
    end
    working = parse_active_next && head_entry.live;
    done    = 1'b0;
    code    = VerdictAllow;
    if (working) begin
      priority if (pos < PosW'(4)) begin
        port_pair_next = {port_pair_next[23:0], b};
        if (pos == PosW'(1) && port_pair_next[15:0] == 16'h0) begin
          done = 1'b1;
          code = VerdictSrcZero;
        end else if (pos == PosW'(3) && port_pair_next[15:0] == 16'h0) begin
          done = 1'b1;
          code = VerdictDstZero;
        end
      end else if (pos < PosW'(8)) begin
        seq_value_next = {seq_value_next[23:0], b};
      end else if (pos < PosW'(12)) begin
        ack_value_next = {ack_value_next[23:0], b};
      end else if (pos == PosW'(12)) begin
        offset_and_flags_next = {4'((b & OffsetMask) >> 4), 8'h00};
        if ((b & ReservedMask) != 8'h00) begin
          done = 1'b1;
          code = VerdictReserved;
        end
      end else if (pos == PosW'(13)) begin
        offset_and_flags_next = {offset_and_flags_next[11:8], b};
        if (b == 8'h00) begin
          done = 1'b1;
          code = VerdictFlagNull;
        end
      end else begin
        tail_fields_next = {tail_fields_next[39:0], b};
        if (pos >= PosLast) begin
          done = 1'b1;
          code = VerdictAllow;
        end
      end
    end
    if (done) begin
      parse_active_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_active <= 1'b0;
    end else if (pop) begin
      parse_active <= parse_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      port_pair        <= port_pair_next;
      seq_value        <= seq_value_next;
      ack_value        <= ack_value_next;
      offset_and_flags <= offset_and_flags_next;
      tail_fields      <= tail_fields_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && done) begin
      verdict               <= code;
      source_port           <= port_pair_next[31:16];
      destination_port      <= port_pair_next[15:0];
      sequence_number       <= seq_value_next;
      acknowledgment_number <= ack_value_next;
      header_words          <= offset_and_flags_next[11:8];
      flag_bits             <= offset_and_flags_next[7:0];
      window_size           <= tail_fields_next[47:32];
      header_checksum       <= tail_fields_next[31:16];
      urgent_pointer        <= tail_fields_next[15:0];
    end
  end

endmodule

[design/tcp_header_parse_check.sv]
// The deciding byte is pushed into the queue, and the result register loads when the
// back pops that byte. Throughput: one byte per cycle while the queue is not full;
// the back consumes a queued byte every cycle the result register is empty or being
// taken, and the 4-entry queue absorbs stalls.
// Reset (rst, synchronous): queue emptied, no parse active, no result pending;
// bytes before the first start are dropped.
// ----------------------------------------------------------------------------
// tcp_header_parse_check
// Byte-serial TCP header parser with source/destination port, reserved nibble
// and null-flag checks; at most one result transaction per header.
// ----------------------------------------------------------------------------
module tcp_header_parse_check (
  input  logic        clk,
  input  logic        rst,
  // input channel: one header byte per transaction
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        start_of_header,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  verdict,
  output logic [15:0] source_port,
  output logic [15:0] destination_port,
  output logic [31:0] sequence_number,
  output logic [31:0] acknowledgment_number,
  output logic [3:0]  header_words,
  output logic [7:0]  flag_bits,
  output logic [15:0] window_size,
  output logic [15:0] header_checksum,
  output logic [15:0] urgent_pointer
);
  import tcphp_pkg::*;

  logic   take;
  logic   q_full;
  logic   q_pop;
  logic   q_valid;
  entry_t front_entry;
  entry_t head_entry;

  // the input side only stalls when the queue is full
  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  // front: tag each byte with its index in the current header window
  tcphp_front u_front (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .data_byte       (data_byte),
    .start_of_header (start_of_header),
    .entry           (front_entry)
  );

  // decouples input acceptance from result back-pressure
  tcphp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (take),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (head_entry)
  );

  // back: field capture, checks, result register
  tcphp_back u_back (
    .clk                   (clk),
    .rst                   (rst),
    .head_valid            (q_valid),
    .head_entry            (head_entry),
    .pop                   (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .verdict               (verdict),
    .source_port           (source_port),
    .destination_port      (destination_port),
    .sequence_number       (sequence_number),
    .acknowledgment_number (acknowledgment_number),
    .header_words          (header_words),
    .flag_bits             (flag_bits),
    .window_size           (window_size),
    .header_checksum       (header_checksum),
    .urgent_pointer        (urgent_pointer)
  );

endmodule

[design/tcphp_checker.sv]
// ----------------------------------------------------------------------------
// tcphp_checker
// Port-level checks on the result stream of tcp_header_parse_check.
// ----------------------------------------------------------------------------
module tcphp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  verdict,
  input logic [15:0] source_port,
  input logic [15:0] destination_port,
  input logic [7:0]  flag_bits,
  input logic [15:0] window_size
);
  import tcphp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(verdict) && $stable(source_port))
    else $error("result changed while stalled");

  a_src: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == VerdictSrcZero |-> source_port == 16'h0
      && destination_port == 16'h0)
    else $error("source port verdict with bad fields");

  a_dst: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == VerdictDstZero |-> source_port != 16'h0
      && destination_port == 16'h0)
    else $error("destination port verdict with bad fields");

  a_early: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == VerdictReserved |-> flag_bits == 8'h0 && window_size == 16'h0)
    else $error("reserved verdict carries later fields");

  a_allow: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == VerdictAllow |-> source_port != 16'h0
      && destination_port != 16'h0 && flag_bits != 8'h0)
    else $error("allow verdict on a failing header");

endmodule

bind tcp_header_parse_check tcphp_checker u_tcphp_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .verdict          (verdict),
  .source_port      (source_port),
  .destination_port (destination_port),
  .flag_bits        (flag_bits),
  .window_size      (window_size)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tcp_header_parse_check. Header bytes are queued by
// an initial block, driven by a clocked driver with random gaps and checked
// by a clocked monitor against an in-bench model of the parse and the four
// sanity checks. The result side stalls at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcphp_pkg::*;

  // run limits: the slowest legal run is roughly 2k bytes with random gaps plus
  // a few hundred results with random stalls
  localparam int CycleLimit  = 400000;
  localparam int SettleTicks = 10;     // margin after the last result is taken
  localparam int ByteTarget  = 1800;   // decisive random bytes to send
  localparam int DrainEvery  = 600;

  // kinds of generated header
  typedef enum int {
    HdrAllow,
    HdrSrcZero,
    HdrDstZero,
    HdrReserved,
    HdrFlagNull
  } hdr_kind_e;

  // one queued input byte; a drain entry is not driven, it holds the
  // sender until every outstanding result has been taken
  typedef struct {
    logic [7:0] data;
    logic       start;
    logic       drain;
  } hdr_byte_t;

  // one parse result, field order matches the port list
  typedef struct packed {
    logic [2:0]  verdict;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [3:0]  words;
    logic [7:0]  flags;
    logic [15:0] win;
    logic [15:0] csum;
    logic [15:0] urg;
  } hdr_result_t;

  // DUT interface
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        start_of_header = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  verdict;
  logic [15:0] source_port;
  logic [15:0] destination_port;
  logic [31:0] sequence_number;
  logic [31:0] acknowledgment_number;
  logic [3:0]  header_words;
  logic [7:0]  flag_bits;
  logic [15:0] window_size;
  logic [15:0] header_checksum;
  logic [15:0] urgent_pointer;

  // bench state
  hdr_byte_t   byte_q[$];      // bytes waiting to be driven
  hdr_result_t verdict_q[$];   // predicted results, oldest first
  int          mismatches  = 0;
  int          cycle_count = 0;
  bit          in_taken    = 1'b0;  // set at posedge when a byte was accepted
  int          send_wait   = 0;
  int          send_run    = 0;
  bit          send_quiet  = 1'b0;
  int          recv_wait   = 0;
  int          recv_run    = 0;
  bit          recv_quiet  = 1'b0;

  // parser model state
  logic [4:0]  hp_pos    = '0;
  logic        hp_active = 1'b0;
  logic [31:0] hp_ports  = '0;
  logic [31:0] hp_seq    = '0;
  logic [31:0] hp_ack    = '0;
  logic [11:0] hp_offfl  = '0;
  logic [47:0] hp_tail   = '0;

  tcp_header_parse_check uut (
    .clk                   (clk),
    .rst                   (rst),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .data_byte             (data_byte),
    .start_of_header       (start_of_header),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .verdict               (verdict),
    .source_port           (source_port),
    .destination_port      (destination_port),
    .sequence_number       (sequence_number),
    .acknowledgment_number (acknowledgment_number),
    .header_words          (header_words),
    .flag_bits             (flag_bits),
    .window_size           (window_size),
    .header_checksum       (header_checksum),
    .urgent_pointer        (urgent_pointer)
  );

  always #5 clk = ~clk;

  // Per-transaction wait draw. Runs of 20..60 transactions are either fully
  // back-to-back or random, so both dense and sparse traffic show up.
  function automatic int draw_wait(inout int run_left, inout bit no_idle);
    if (run_left == 0) begin
      no_idle  = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(20, 60);
    end
    run_left--;
    if (no_idle) return 0;
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  // Model of the parser: consume one accepted byte, queue a result when the
  // parse ends (first failing check, or byte 19 with all checks passed).
  task automatic predict_header_byte(input logic [7:0] b, input logic sof);
    logic [4:0]  pos;
    logic [2:0]  code;
    logic        done;
    logic [7:0]  offset_bits;
    hdr_result_t r;
    code = VerdictAllow;
    done = 1'b0;
    // a start mark drops any parse in progress and clears every field
    if (sof) begin
      hp_pos    = '0;
      hp_ports  = '0;
      hp_seq    = '0;
      hp_ack    = '0;
      hp_offfl  = '0;
      hp_tail   = '0;
      hp_active = 1'b1;
    end
    // no parse open: the byte is dropped
    if (!hp_active) return;
    pos = hp_pos;
    if (pos < 4) begin
      hp_ports = {hp_ports[23:0], b};
      if (pos == 1 && hp_ports[15:0] == 16'h0000) begin
        code = VerdictSrcZero;
        done = 1'b1;
      end else if (pos == 3 && hp_ports[15:0] == 16'h0000) begin
        code = VerdictDstZero;
        done = 1'b1;
      end
    end else if (pos < 8) begin
      hp_seq = {hp_seq[23:0], b};
    end else if (pos < 12) begin
      hp_ack = {hp_ack[23:0], b};
    end else if (pos == 12) begin
      // data offset is kept even when the reserved nibble fails
      offset_bits = b & OffsetMask;
      hp_offfl    = {offset_bits[7:4], 8'h00};
      if ((b & ReservedMask) != 8'h00) begin
        code = VerdictReserved;
        done = 1'b1;
      end
    end else if (pos == 13) begin
      hp_offfl[7:0] = b;
      if (b == 8'h00) begin
        code = VerdictFlagNull;
        done = 1'b1;
      end
    end else begin
      hp_tail = {hp_tail[39:0], b};
      if (pos >= PosLast) done = 1'b1;
    end
    hp_pos = pos + 5'd1;
    if (done) begin
      hp_active = 1'b0;
      r.verdict = code;
      r.sport   = hp_ports[31:16];
      r.dport   = hp_ports[15:0];
      r.seq     = hp_seq;
      r.ack     = hp_ack;
      r.words   = hp_offfl[11:8];
      r.flags   = hp_offfl[7:0];
      r.win     = hp_tail[47:32];
      r.csum    = hp_tail[31:16];
      r.urg     = hp_tail[15:0];
      verdict_q.push_back(r);
    end
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic push_byte(input logic [7:0] d, input logic sof);
    hdr_byte_t it;
    it.data  = d;
    it.start = sof;
    it.drain = 1'b0;
    byte_q.push_back(it);
  endtask

  task automatic push_drain();
    hdr_byte_t it;
    it.data  = 8'h00;
    it.start = 1'b0;
    it.drain = 1'b1;
    byte_q.push_back(it);
  endtask

  // queue the first len bytes of a 20-byte header image, byte 0 in the MSBs
  task automatic push_fixed(input logic [159:0] hdr, input int len);
    int i;
    for (i = 0; i < len; i++) push_byte(hdr[159-8*i -: 8], i == 0);
  endtask

  // random header of the given kind; fields lean toward 0x00 / 0xFF bytes
  task automatic push_random_header(input hdr_kind_e kind, input int len);
    logic [159:0] hdr;
    logic [7:0]   b;
    int           i;
    for (i = 0; i < 20; i++) begin
      case ($urandom_range(0, 7))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      hdr[159-8*i -: 8] = b;
    end
    // make the passing case pass, then break the one check the kind targets
    if (hdr[159:144] == 16'h0000) hdr[151:144] = 8'($urandom_range(1, 255));
    if (hdr[143:128] == 16'h0000) hdr[135:128] = 8'($urandom_range(1, 255));
    hdr[63:56] = hdr[63:56] & OffsetMask;
    if (hdr[55:48] == 8'h00) hdr[55:48] = 8'($urandom_range(1, 255));
    case (kind)
      HdrSrcZero:  hdr[159:144] = 16'h0000;
      HdrDstZero:  hdr[143:128] = 16'h0000;
      HdrReserved: hdr[59:56]   = 4'($urandom_range(1, 15));
      HdrFlagNull: hdr[55:48]   = 8'h00;
      default: ;
    endcase
    push_fixed(hdr, len);
  endtask

  // Driver: inputs move on the falling edge. The new valid is worked out in
  // a local so that valid gets a single nonblocking update per edge.
  always @(negedge clk) begin : drive_proc
    logic      nxt_valid;
    hdr_byte_t cur;
    if (!rst) begin
      nxt_valid = in_valid;
      if (in_taken) begin
        nxt_valid = 1'b0;
        in_taken  = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (byte_q.size() > 0) begin
          if (byte_q[0].drain) begin
            // hold until every predicted result has been taken
            if (verdict_q.size() == 0) byte_q.delete(0);
          end else begin
            cur = byte_q.pop_front();
            data_byte       <= cur.data;
            start_of_header <= cur.start;
            nxt_valid = 1'b1;
            send_wait = draw_wait(send_run, send_quiet);
          end
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Result side backpressure: stall for the drawn number of cycles
  always @(negedge clk) begin : stall_proc
    if (!rst && recv_wait > 0) begin
      out_stall <= 1'b1;
      recv_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: both channels sampled at the rising edge.
  always @(posedge clk) begin : watch_proc
    hdr_result_t got;
    hdr_result_t want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t ns: timeout, %0d results still expected", $time, verdict_q.size());
      $display("[tcp_header_parse_check] ERROR");
      $finish;
    end else if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_header_byte(data_byte, start_of_header);
        in_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got = {verdict, source_port, destination_port, sequence_number,
               acknowledgment_number, header_words, flag_bits, window_size,
               header_checksum, urgent_pointer};
        if (verdict_q.size() == 0) begin
          $display("%0t ns: unexpected result transaction, expected none, got verdict %0d",
                   $time, verdict);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          cmp_field("verdict",               32'(want.verdict), 32'(got.verdict));
          cmp_field("source_port",           32'(want.sport),   32'(got.sport));
          cmp_field("destination_port",      32'(want.dport),   32'(got.dport));
          cmp_field("sequence_number",       want.seq,          got.seq);
          cmp_field("acknowledgment_number", want.ack,          got.ack);
          cmp_field("header_words",          32'(want.words),   32'(got.words));
          cmp_field("flag_bits",             32'(want.flags),   32'(got.flags));
          cmp_field("window_size",           32'(want.win),     32'(got.win));
          cmp_field("header_checksum",       32'(want.csum),    32'(got.csum));
          cmp_field("urgent_pointer",        32'(want.urg),     32'(got.urg));
        end
        recv_wait = draw_wait(recv_run, recv_quiet);
      end
    end
  end

  // Stimulus, reset and end of test
  initial begin : main_proc
    int        counted;
    int        next_drain;
    int        pick;
    int        len;
    hdr_kind_e kind;

    // ---- directed ----
    // bytes before any start mark are dropped
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b0);
    // start mark in the middle of a parse: fragment is dropped silently
    push_fixed({16'h1234, 16'h5678, 128'h0}, 3);
    // every field at its maximum, reserved nibble clear: allow
    push_fixed({16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                8'hF0, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 20);
    // byte after a result with no start: ignored
    push_byte(8'h77, 1'b0);
    // source port zero, the trailing byte is ignored
    push_fixed({16'h0000, 16'hFFFF, 128'h0}, 3);
    // destination port zero, low byte of source zero but port nonzero
    push_fixed({16'h0100, 16'h0000, 128'h0}, 4);
    // reserved nibble set; header_words is already captured
    push_fixed({16'h8000, 16'h0080, 32'h0000_0001, 32'h8000_0000,
                8'hA1, 8'h00, 48'h0}, 13);
    // null flag byte, header_words zero
    push_fixed({16'h0001, 16'h0001, 32'h0, 32'h0, 8'h00, 8'h00, 48'h0}, 14);
    push_drain();

    // ---- random ----
    counted    = 0;
    next_drain = DrainEvery;
    while (counted < ByteTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 84) begin
        // complete header; failing kinds stop up to 3 bytes past the decision
        if (pick < 60)      kind = HdrAllow;
        else if (pick < 66) kind = HdrSrcZero;
        else if (pick < 72) kind = HdrDstZero;
        else if (pick < 78) kind = HdrReserved;
        else                kind = HdrFlagNull;
        case (kind)
          HdrSrcZero:  len = 2;
          HdrDstZero:  len = 4;
          HdrReserved: len = 13;
          HdrFlagNull: len = 14;
          default:     len = HeaderBytes;
        endcase
        counted += len;
        if (kind != HdrAllow) len += $urandom_range(0, 3);
        push_random_header(kind, (len > HeaderBytes) ? HeaderBytes : len);
        if (kind == HdrAllow && $urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
        end
      end else if (pick < 92) begin
        // header cut short; the next start mark drops it
        len = $urandom_range(1, HeaderBytes - 1);
        counted += len;
        push_random_header(HdrAllow, len);
      end else begin
        // noise: loose bytes with an occasional stray start mark
        len = $urandom_range(1, 6);
        counted += len;
        repeat (len) push_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end
      if (counted >= next_drain) begin
        push_drain();
        next_drain += DrainEvery;
      end
    end

    // ---- reset ----
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ---- wait for everything to drain ----
    while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (SettleTicks) @(posedge clk);

    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("[tcp_header_parse_check] OK");
    end else begin
      $display("[tcp_header_parse_check] ERROR");
    end
    $finish;
  end

endmodule
